[hdl/ucep_pkg.sv]
// shared types, codes and constants for the usb control endpoint sequencer
package ucep_pkg;

  localparam int PACKET_BYTES = 64;
  localparam int MAX_TRANSFER = 4096;

  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int PLEN_W = 7;
  localparam int TLEN_W = 13;
  localparam int ACT_W  = 3;
  localparam int MODE_W = 3;

  localparam logic [TLEN_W-1:0] PKT_LEN = TLEN_W'(PACKET_BYTES);
  localparam logic [TLEN_W-1:0] MAX_LEN = TLEN_W'(MAX_TRANSFER);

  localparam logic [BYTE_W-1:0] RT_STD_DEVICE    = 8'h00;
  localparam logic [BYTE_W-1:0] RT_STD_INTERFACE = 8'h01;
  localparam logic [BYTE_W-1:0] REQ_SET_ADDRESS  = 8'd5;
  localparam logic [BYTE_W-1:0] REQ_SET_CONFIG   = 8'd9;
  localparam logic [BYTE_W-1:0] REQ_SET_IFACE    = 8'd11;
  localparam int                RT_DIR_BIT       = 7;

  typedef enum logic [OP_W-1:0] {
    OP_BUS_RESET = 3'd0,
    OP_SETUP     = 3'd1,
    OP_OUT_RX    = 3'd2,
    OP_IN_SENT   = 3'd3,
    OP_START     = 3'd4,
    OP_CANCEL    = 3'd5
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE     = 3'd0,
    MODE_DATA_IN  = 3'd1,
    MODE_DATA_OUT = 3'd2,
    MODE_ADDRESS  = 3'd3,
    MODE_STATUS   = 3'd4
  } mode_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE       = 3'd0,
    ACT_STATUS_IN  = 3'd1,
    ACT_STATUS_OUT = 3'd2,
    ACT_STALL      = 3'd3,
    ACT_ARM_OUT    = 3'd4,
    ACT_TX         = 3'd5
  } act_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] request_type;
    logic [BYTE_W-1:0] request_code;
    logic [PLEN_W-1:0] packet_length;
    logic [TLEN_W-1:0] transfer_length;
    logic              direction_in;
    logic              partial;
  } step_in_t;

  typedef struct packed {
    mode_t             mode;
    logic [TLEN_W-1:0] position;
    logic [TLEN_W-1:0] end_length;
    logic              partial_flag;
    logic              transfer_active;
    logic              configured;
  } ctrl_state_t;

  typedef struct packed {
    act_t              action;
    logic [PLEN_W-1:0] tx_length;
    logic              apply_address;
    logic              request_to_app;
    logic              now_configured;
    logic              transfer_done;
    logic [TLEN_W-1:0] transferred_bytes;
    logic              rejected;
    mode_t             control_mode;
  } step_result_t;

endpackage

[hdl/usb_control_endpoint_sequencer.sv]
// top level of the usb control endpoint sequencer
//
//   channel  direction  handshake             words
//   in_      input      in_valid / in_ready   one endpoint event
//   out_     output     out_valid / out_ready one result per event
//
// the step logic reads the event ports and the state registers, and the result
// lands in the output register at the accept edge
// a new event is accepted every cycle while the output register is empty or
// being taken; a stalled result holds and blocks only further events
// synchronous active-low reset returns the endpoint to idle, not configured
module usb_control_endpoint_sequencer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ucep_pkg::OP_W-1:0]    in_operation,
  input  logic [ucep_pkg::BYTE_W-1:0]  in_request_type,
  input  logic [ucep_pkg::BYTE_W-1:0]  in_request_code,
  input  logic [ucep_pkg::PLEN_W-1:0]  in_packet_length,
  input  logic [ucep_pkg::TLEN_W-1:0]  in_transfer_length,
  input  logic                         in_direction_in,
  input  logic                         in_partial,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ucep_pkg::ACT_W-1:0]   out_action,
  output logic [ucep_pkg::PLEN_W-1:0]  out_tx_length,
  output logic                         out_apply_address,
  output logic                         out_request_to_app,
  output logic                         out_now_configured,
  output logic                         out_transfer_done,
  output logic [ucep_pkg::TLEN_W-1:0]  out_transferred_bytes,
  output logic                         out_rejected,
  output logic [ucep_pkg::MODE_W-1:0]  out_control_mode
);
  import ucep_pkg::*;

  step_in_t     step_in;
  ctrl_state_t  st_r;
  ctrl_state_t  st_nxt;
  step_result_t res;
  step_result_t res_r;
  logic         out_valid_r;
  logic         in_accept;

  assign step_in.operation       = in_operation;
  assign step_in.request_type    = in_request_type;
  assign step_in.request_code    = in_request_code;
  assign step_in.packet_length   = in_packet_length;
  assign step_in.transfer_length = in_transfer_length;
  assign step_in.direction_in    = in_direction_in;
  assign step_in.partial         = in_partial;

  ucep_step u_step (
    .step_in (step_in),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  // all-zero state is idle, not configured
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        st_r <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_action            = res_r.action;
  assign out_tx_length         = res_r.tx_length;
  assign out_apply_address     = res_r.apply_address;
  assign out_request_to_app    = res_r.request_to_app;
  assign out_now_configured    = res_r.now_configured;
  assign out_transfer_done     = res_r.transfer_done;
  assign out_transferred_bytes = res_r.transferred_bytes;
  assign out_rejected          = res_r.rejected;
  assign out_control_mode      = res_r.control_mode;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid)
    else $error("accepted word produced no result");

  a_tx_length_only_on_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action != ACT_TX) |-> out_tx_length == '0)
    else $error("tx length set without transmit");

  a_done_not_continuing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_transfer_done |->
      (out_action != ACT_TX) && (out_action != ACT_ARM_OUT) && !out_rejected)
    else $error("finished transfer still continuing");

  a_ready_in_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_now_configured |-> out_control_mode == MODE_STATUS)
    else $error("configured outside status stage");

  a_idle_no_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode == MODE_IDLE) || (st_r.mode == MODE_ADDRESS) |-> !st_r.transfer_active)
    else $error("transfer active outside a data mode");

endmodule

[hdl/ucep_step.sv]
// next-state and result logic for one endpoint event
module ucep_step (
  input  ucep_pkg::step_in_t     step_in,
  input  ucep_pkg::ctrl_state_t  st,
  output ucep_pkg::ctrl_state_t  st_nxt,
  output ucep_pkg::step_result_t res
);
  import ucep_pkg::*;

  logic [TLEN_W-1:0] rem;
  logic [TLEN_W-1:0] plen_ext;
  logic [TLEN_W-1:0] copied;
  logic [TLEN_W-1:0] out_pos;
  logic [TLEN_W-1:0] sent;
  logic [TLEN_W-1:0] in_pos;
  logic [TLEN_W-1:0] in_rem;
  logic [TLEN_W-1:0] in_tx;
  logic [TLEN_W-1:0] start_len;
  logic [TLEN_W-1:0] start_tx;
  mode_t             want_mode;

  assign rem       = st.end_length - st.position;
  assign plen_ext  = TLEN_W'(step_in.packet_length);
  assign copied    = (plen_ext < rem) ? plen_ext : rem;
  assign out_pos   = st.position + copied;
  assign sent      = (rem < PKT_LEN) ? rem : PKT_LEN;
  assign in_pos    = st.position + sent;
  assign in_rem    = st.end_length - in_pos;
  assign in_tx     = (in_rem < PKT_LEN) ? in_rem : PKT_LEN;
  assign start_len = (step_in.transfer_length < MAX_LEN) ? step_in.transfer_length : MAX_LEN;
  assign start_tx  = (start_len < PKT_LEN) ? start_len : PKT_LEN;
  assign want_mode = step_in.direction_in ? MODE_DATA_IN : MODE_DATA_OUT;

  always_comb begin
    st_nxt = st;
    res = '0;
    res.action = ACT_NONE;
    res.control_mode = MODE_IDLE;
    unique case (op_t'(step_in.operation))
      OP_BUS_RESET: begin
        st_nxt = '0;
        st_nxt.mode = MODE_IDLE;
      end
      OP_SETUP: begin
        st_nxt.transfer_active = 1'b0;
        if (step_in.request_type == RT_STD_DEVICE && step_in.request_code == REQ_SET_ADDRESS) begin
          res.action = ACT_STATUS_IN;
          st_nxt.mode = MODE_ADDRESS;
        end else if (step_in.request_type == RT_STD_DEVICE &&
                     step_in.request_code == REQ_SET_CONFIG) begin
          res.action = ACT_STATUS_IN;
          st_nxt.mode = MODE_STATUS;
          res.now_configured = !st.configured;
          st_nxt.configured = 1'b1;
        end else if (step_in.request_type == RT_STD_INTERFACE &&
                     step_in.request_code == REQ_SET_IFACE) begin
          res.action = ACT_STATUS_IN;
          st_nxt.mode = MODE_STATUS;
        end else begin
          st_nxt.mode = step_in.request_type[RT_DIR_BIT] ? MODE_DATA_IN : MODE_DATA_OUT;
          res.request_to_app = 1'b1;
        end
      end
      OP_OUT_RX: begin
        if (st.mode == MODE_DATA_OUT) begin
          if (st.transfer_active) begin
            st_nxt.position = out_pos;
            if (out_pos < st.end_length && copied >= PKT_LEN) begin
              res.action = ACT_ARM_OUT;
            end else begin
              res.transfer_done = 1'b1;
              res.transferred_bytes = out_pos;
              st_nxt.transfer_active = 1'b0;
              if (!st.partial_flag) begin
                res.action = ACT_STATUS_IN;
                st_nxt.mode = MODE_STATUS;
              end
            end
          end
        end else begin
          st_nxt.transfer_active = 1'b0;
          st_nxt.mode = MODE_IDLE;
          res.action = ACT_STALL;
        end
      end
      OP_IN_SENT: begin
        if (st.mode == MODE_DATA_IN) begin
          if (st.transfer_active) begin
            st_nxt.position = in_pos;
            if (in_pos < st.end_length || (!st.partial_flag && sent == PKT_LEN)) begin
              res.action = ACT_TX;
              res.tx_length = in_tx[PLEN_W-1:0];
            end else begin
              res.transfer_done = 1'b1;
              res.transferred_bytes = in_pos;
              st_nxt.transfer_active = 1'b0;
              if (!st.partial_flag) begin
                res.action = ACT_STATUS_OUT;
                st_nxt.mode = MODE_STATUS;
              end
            end
          end
        end else begin
          res.apply_address = (st.mode == MODE_ADDRESS);
          st_nxt.transfer_active = 1'b0;
          st_nxt.mode = MODE_IDLE;
          res.action = ACT_STALL;
        end
      end
      OP_START: begin
        if (st.transfer_active || st.mode != want_mode) begin
          res.rejected = 1'b1;
        end else begin
          st_nxt.position = '0;
          st_nxt.end_length = start_len;
          st_nxt.partial_flag = step_in.partial;
          st_nxt.transfer_active = 1'b1;
          if (step_in.direction_in) begin
            res.action = ACT_TX;
            res.tx_length = start_tx[PLEN_W-1:0];
          end else begin
            res.action = ACT_ARM_OUT;
          end
        end
      end
      OP_CANCEL: begin
        st_nxt.transfer_active = 1'b0;
      end
      default: begin
      end
    endcase
    res.control_mode = st_nxt.mode;
  end

endmodule

[dv/tb_usb_control_endpoint_sequencer.sv]
// testbench for the usb control endpoint sequencer: event stimulus with a built-in endpoint model
module tb_usb_control_endpoint_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import ucep_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_operation = '0;
  logic [BYTE_W-1:0]   in_request_type = '0;
  logic [BYTE_W-1:0]   in_request_code = '0;
  logic [PLEN_W-1:0]   in_packet_length = '0;
  logic [TLEN_W-1:0]   in_transfer_length = '0;
  logic                in_direction_in = 1'b0;
  logic                in_partial = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ACT_W-1:0]    out_action;
  logic [PLEN_W-1:0]   out_tx_length;
  logic                out_apply_address;
  logic                out_request_to_app;
  logic                out_now_configured;
  logic                out_transfer_done;
  logic [TLEN_W-1:0]   out_transferred_bytes;
  logic                out_rejected;
  logic [MODE_W-1:0]   out_control_mode;

  usb_control_endpoint_sequencer i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_operation          (in_operation),
    .in_request_type       (in_request_type),
    .in_request_code       (in_request_code),
    .in_packet_length      (in_packet_length),
    .in_transfer_length    (in_transfer_length),
    .in_direction_in       (in_direction_in),
    .in_partial            (in_partial),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_action            (out_action),
    .out_tx_length         (out_tx_length),
    .out_apply_address     (out_apply_address),
    .out_request_to_app    (out_request_to_app),
    .out_now_configured    (out_now_configured),
    .out_transfer_done     (out_transfer_done),
    .out_transferred_bytes (out_transferred_bytes),
    .out_rejected          (out_rejected),
    .out_control_mode      (out_control_mode)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  step_in_t     event_q[$];
  step_result_t expected_replies[$];
  ctrl_state_t  ctrl = '0;

  step_in_t     nxt;
  step_in_t     seen;
  step_result_t got;
  step_result_t want;

  logic in_took = 1'b0;
  logic idle_on = 1'b1;
  int   in_gap = 0;
  int   out_gap = 0;
  int   n_queued = 0;
  int   n_results = 0;
  int   n_errors = 0;
  int   n_done = 0;
  int   n_refused = 0;
  int   n_stalls = 0;

  // endpoint model: one result per event
  function automatic step_result_t advance_endpoint(step_in_t ev);
    step_result_t      r;
    logic [TLEN_W-1:0] left;
    logic [TLEN_W-1:0] moved_now;
    r = '0;
    case (ev.operation)
      OP_BUS_RESET: ctrl = '0;
      OP_SETUP: begin
        ctrl.transfer_active = 1'b0;
        if (ev.request_type == RT_STD_DEVICE && ev.request_code == REQ_SET_ADDRESS) begin
          r.action = ACT_STATUS_IN;
          ctrl.mode = MODE_ADDRESS;
        end else if (ev.request_type == RT_STD_DEVICE && ev.request_code == REQ_SET_CONFIG) begin
          r.action = ACT_STATUS_IN;
          ctrl.mode = MODE_STATUS;
          r.now_configured = !ctrl.configured;
          ctrl.configured = 1'b1;
        end else if (ev.request_type == RT_STD_INTERFACE &&
                     ev.request_code == REQ_SET_IFACE) begin
          r.action = ACT_STATUS_IN;
          ctrl.mode = MODE_STATUS;
        end else begin
          ctrl.mode = ev.request_type[RT_DIR_BIT] ? MODE_DATA_IN : MODE_DATA_OUT;
          r.request_to_app = 1'b1;
        end
      end
      OP_OUT_RX: begin
        if (ctrl.mode == MODE_DATA_OUT) begin
          if (ctrl.transfer_active) begin
            left = ctrl.end_length - ctrl.position;
            moved_now = (TLEN_W'(ev.packet_length) < left) ? TLEN_W'(ev.packet_length) : left;
            ctrl.position = ctrl.position + moved_now;
            if (ctrl.position < ctrl.end_length && moved_now >= PKT_LEN) begin
              r.action = ACT_ARM_OUT;
            end else begin
              r.transfer_done = 1'b1;
              r.transferred_bytes = ctrl.position;
              ctrl.transfer_active = 1'b0;
              if (!ctrl.partial_flag) begin
                r.action = ACT_STATUS_IN;
                ctrl.mode = MODE_STATUS;
              end
            end
          end
        end else begin
          ctrl.transfer_active = 1'b0;
          ctrl.mode = MODE_IDLE;
          r.action = ACT_STALL;
        end
      end
      OP_IN_SENT: begin
        if (ctrl.mode == MODE_DATA_IN) begin
          if (ctrl.transfer_active) begin
            left = ctrl.end_length - ctrl.position;
            moved_now = (left < PKT_LEN) ? left : PKT_LEN;
            ctrl.position = ctrl.position + moved_now;
            if (ctrl.position < ctrl.end_length ||
                (!ctrl.partial_flag && moved_now == PKT_LEN)) begin
              r.action = ACT_TX;
              left = ctrl.end_length - ctrl.position;
              r.tx_length = PLEN_W'((left < PKT_LEN) ? left : PKT_LEN);
            end else begin
              r.transfer_done = 1'b1;
              r.transferred_bytes = ctrl.position;
              ctrl.transfer_active = 1'b0;
              if (!ctrl.partial_flag) begin
                r.action = ACT_STATUS_OUT;
                ctrl.mode = MODE_STATUS;
              end
            end
          end
        end else begin
          r.apply_address = (ctrl.mode == MODE_ADDRESS);
          ctrl.transfer_active = 1'b0;
          ctrl.mode = MODE_IDLE;
          r.action = ACT_STALL;
        end
      end
      OP_START: begin
        if (ctrl.transfer_active ||
            ctrl.mode != (ev.direction_in ? MODE_DATA_IN : MODE_DATA_OUT)) begin
          r.rejected = 1'b1;
        end else begin
          ctrl.position = '0;
          ctrl.end_length = (ev.transfer_length < MAX_LEN) ? ev.transfer_length : MAX_LEN;
          ctrl.partial_flag = ev.partial;
          ctrl.transfer_active = 1'b1;
          if (ev.direction_in) begin
            r.action = ACT_TX;
            r.tx_length = PLEN_W'((ctrl.end_length < PKT_LEN) ? ctrl.end_length : PKT_LEN);
          end else begin
            r.action = ACT_ARM_OUT;
          end
        end
      end
      OP_CANCEL: ctrl.transfer_active = 1'b0;
      default: ;
    endcase
    r.control_mode = ctrl.mode;
    return r;
  endfunction

  function automatic string fmt_result(step_result_t r);
    return $sformatf("act %0d tx %0d addr %0b app %0b cfgd %0b done %0b bytes %0d rej %0b mode %0d",
                     r.action, r.tx_length, r.apply_address, r.request_to_app, r.now_configured,
                     r.transfer_done, r.transferred_bytes, r.rejected, r.control_mode);
  endfunction

  // unused fields of an event carry random content
  function automatic step_in_t ev_of(logic [OP_W-1:0] op);
    step_in_t e;
    e.operation = op;
    e.request_type = BYTE_W'($urandom);
    e.request_code = BYTE_W'($urandom);
    e.packet_length = PLEN_W'($urandom);
    e.transfer_length = TLEN_W'($urandom);
    e.direction_in = 1'($urandom);
    e.partial = 1'($urandom);
    return e;
  endfunction

  function automatic int pick_len();
    int k;
    k = $urandom_range(0, 19);
    if (k < 12) return $urandom_range(0, 200);
    if (k < 16) return 64 * $urandom_range(1, 3) - 1 + $urandom_range(0, 2);
    if (k < 19) return $urandom_range(0, 1000);
    return $urandom_range(0, 8191);
  endfunction

  task automatic queue_ev(step_in_t e);
    event_q.push_back(e);
    n_queued++;
  endtask

  task automatic setup_ev(logic [BYTE_W-1:0] rt, logic [BYTE_W-1:0] rc);
    step_in_t e;
    e = ev_of(OP_SETUP);
    e.request_type = rt;
    e.request_code = rc;
    queue_ev(e);
  endtask

  task automatic start_ev(logic [TLEN_W-1:0] tl, logic di, logic pa);
    step_in_t e;
    e = ev_of(OP_START);
    e.transfer_length = tl;
    e.direction_in = di;
    e.partial = pa;
    queue_ev(e);
  endtask

  task automatic out_ev(logic [PLEN_W-1:0] pl);
    step_in_t e;
    e = ev_of(OP_OUT_RX);
    e.packet_length = pl;
    queue_ev(e);
  endtask

  // mostly well-formed control transfers, the rest broken sequences and noise
  task automatic add_random(int want_items);
    int   stop;
    int   kind;
    int   tl;
    int   sat;
    int   left;
    int   pl;
    int   c;
    int   n;
    logic pa;
    stop = n_queued + want_items;
    while (n_queued < stop) begin
      kind = $urandom_range(0, 19);
      tl = pick_len();
      sat = (tl < MAX_TRANSFER) ? tl : MAX_TRANSFER;
      pa = ($urandom_range(0, 3) == 0);
      if (kind < 2) begin
        setup_ev(RT_STD_DEVICE, REQ_SET_ADDRESS);
        queue_ev(ev_of(($urandom_range(0, 4) == 0) ? OP_OUT_RX : OP_IN_SENT));
      end else if (kind < 3) begin
        setup_ev(RT_STD_DEVICE, REQ_SET_CONFIG);
        queue_ev(ev_of(OP_IN_SENT));
      end else if (kind < 4) begin
        setup_ev(RT_STD_INTERFACE, REQ_SET_IFACE);
        queue_ev(ev_of(OP_IN_SENT));
      end else if (kind < 10) begin
        setup_ev(8'h80 | BYTE_W'($urandom), BYTE_W'($urandom));
        if ($urandom_range(0, 9) == 0) start_ev(TLEN_W'(tl), 1'b0, pa);
        start_ev(TLEN_W'(tl), 1'b1, pa);
        n = pa ? ((sat + 63) / 64) : (sat / 64 + 1);
        if (n == 0) n = 1;
        repeat (n) begin
          if ($urandom_range(0, 29) == 0) queue_ev(ev_of(OP_CANCEL));
          queue_ev(ev_of(OP_IN_SENT));
        end
        if (!pa) queue_ev(ev_of(OP_OUT_RX));
      end else if (kind < 16) begin
        setup_ev(BYTE_W'($urandom_range(0, 127)), BYTE_W'($urandom));
        start_ev(TLEN_W'(tl), 1'b0, pa);
        left = sat;
        do begin
          if (left >= 64 && $urandom_range(0, 3) != 0) pl = 64;
          else if ($urandom_range(0, 7) == 0) pl = $urandom_range(0, 127);
          else pl = $urandom_range(0, (left < 63) ? left : 63);
          out_ev(PLEN_W'(pl));
          c = (pl < left) ? pl : left;
          left = left - c;
        end while (c >= 64 && left > 0);
        if (!pa) queue_ev(ev_of(OP_IN_SENT));
      end else if (kind < 18) begin
        setup_ev(BYTE_W'($urandom), BYTE_W'($urandom));
        start_ev(TLEN_W'($urandom_range(0, 150)), 1'($urandom), pa);
        repeat ($urandom_range(1, 4)) queue_ev(ev_of(OP_W'($urandom_range(OP_SETUP, OP_CANCEL))));
      end else begin
        repeat ($urandom_range(1, 3))
          queue_ev(ev_of(OP_W'($urandom_range(OP_BUS_RESET, OP_UNUSED_HI))));
      end
    end
  endtask

  task automatic drain();
    while (event_q.size() != 0 || n_results < n_queued) @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (idle_on && event_q.size() != 0 && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else if (event_q.size() != 0) begin
        nxt = event_q.pop_front();
        in_operation <= nxt.operation;
        in_request_type <= nxt.request_type;
        in_request_code <= nxt.request_code;
        in_packet_length <= nxt.packet_length;
        in_transfer_length <= nxt.transfer_length;
        in_direction_in <= nxt.direction_in;
        in_partial <= nxt.partial;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stalls
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_gap <= $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        got.action = act_t'(out_action);
        got.tx_length = out_tx_length;
        got.apply_address = out_apply_address;
        got.request_to_app = out_request_to_app;
        got.now_configured = out_now_configured;
        got.transfer_done = out_transfer_done;
        got.transferred_bytes = out_transferred_bytes;
        got.rejected = out_rejected;
        got.control_mode = mode_t'(out_control_mode);
        n_results++;
        if (expected_replies.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("result word %0d with nothing expected: %s",
                                       n_results, fmt_result(got));
        end else begin
          want = expected_replies.pop_front();
          if (want.transfer_done) n_done++;
          if (want.rejected) n_refused++;
          if (want.action == ACT_STALL) n_stalls++;
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("result word %0d differs", n_results);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        seen.operation = in_operation;
        seen.request_type = in_request_type;
        seen.request_code = in_request_code;
        seen.packet_length = in_packet_length;
        seen.transfer_length = in_transfer_length;
        seen.direction_in = in_direction_in;
        seen.partial = in_partial;
        expected_replies.push_back(advance_endpoint(seen));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: standard requests, stage errors and transfer corner cases
    setup_ev(RT_STD_DEVICE, REQ_SET_ADDRESS);
    queue_ev(ev_of(OP_IN_SENT));
    setup_ev(RT_STD_DEVICE, REQ_SET_CONFIG);
    out_ev(7'd0);
    setup_ev(RT_STD_DEVICE, REQ_SET_CONFIG);
    queue_ev(ev_of(OP_IN_SENT));
    setup_ev(RT_STD_INTERFACE, REQ_SET_IFACE);
    setup_ev(8'h80, 8'd6);
    start_ev(13'd128, 1'b0, 1'b0);
    start_ev(13'd128, 1'b1, 1'b0);
    start_ev(13'd10, 1'b1, 1'b0);
    repeat (3) queue_ev(ev_of(OP_IN_SENT));
    out_ev(7'd64);
    setup_ev(8'h7f, 8'hff);
    start_ev(13'h1fff, 1'b0, 1'b1);
    out_ev(7'h7f);
    out_ev(7'd0);
    out_ev(7'd64);
    start_ev(13'd0, 1'b0, 1'b0);
    queue_ev(ev_of(OP_CANCEL));
    queue_ev(ev_of(OP_CANCEL));
    start_ev(13'd64, 1'b0, 1'b0);
    setup_ev(RT_STD_DEVICE, REQ_SET_ADDRESS);
    queue_ev(ev_of(OP_UNUSED_LO));
    queue_ev(ev_of(OP_UNUSED_HI));
    queue_ev(ev_of(OP_BUS_RESET));
    drain();

    add_random(950);
    drain();
    add_random(750);
    drain();
    idle_on = 1'b0;
    add_random(250);
    drain();
    repeat (8) @(posedge clk);

    $display("%0d events checked, %0d transfers finished, %0d starts refused, %0d stalls",
             n_results, n_done, n_refused, n_stalls);
    if (n_errors == 0 && expected_replies.size() == 0) begin
      $display("usb_control_endpoint_sequencer: match");
    end else begin
      $display("usb_control_endpoint_sequencer: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d of %0d results seen", n_results, n_queued);
    $display("usb_control_endpoint_sequencer: mismatch");
    $finish;
  end

endmodule
